[hw/rtl/adaptive_lru_clock_replacement_unit_macros.svh]
// Assertion macros shared by the checker of the replacement unit.
`ifndef ADAPTIVE_LRU_CLOCK_REPLACEMENT_UNIT_MACROS_SVH
`define ADAPTIVE_LRU_CLOCK_REPLACEMENT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ALCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ALCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Delayed implication, disabled while reset is high.
`define ALCR_ASSERT_LATER(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

[hw/rtl/alcr_pkg.sv]
// Types, constants and helpers of the adaptive LRU/CLOCK replacement unit.
`timescale 1ns / 1ps
package alcr_pkg;

  localparam int WAYS      = 16;
  localparam int SETS      = 1024;
  localparam int WAY_W     = 4;
  localparam int SET_W     = 10;
  localparam int AGE_W     = 4;
  localparam int CNT_W     = 16;
  localparam int FACTOR_W  = 8;
  localparam int SCORE_W   = 17;
  localparam int PROD_W    = CNT_W + FACTOR_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_VICTIM = 1'b1;

  localparam logic POL_LRU   = 1'b0;
  localparam logic POL_CLOCK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

  localparam logic [CNT_W-1:0]    WINDOW_RST = 16'd1024;
  localparam logic [FACTOR_W-1:0] FACTOR_RST = 8'd3;
  localparam logic [CNT_W-1:0]    LIMIT_RST  = 16'd16;

  typedef struct packed {
    logic             req_type;
    logic [SET_W-1:0] set_index;
    logic [WAY_W-1:0] way;
    logic             hit;
  } req_t;

  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic             victim_valid;
    logic             policy_now;
  } rsp_t;

  typedef struct packed {
    logic [WAYS-1:0][AGE_W-1:0] age;
    logic [WAYS-1:0]            used;
    logic [WAY_W-1:0]           hand;
  } row_t;

  typedef struct packed {
    logic policy_after;
    logic use_lru;
  } pol_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  function automatic row_t reset_row();
    row_t r;
    for (int w = 0; w < WAYS; w++) begin
      r.age[w] = AGE_W'(w);
    end
    r.used = '0;
    r.hand = '0;
    return r;
  endfunction

endpackage

[hw/rtl/alcr_row_ram.sv]
// Per-set row memory with one write port and one registered read port.
`timescale 1ns / 1ps
module alcr_row_ram
  import alcr_pkg::*;
(
  input  logic             clk,
  input  logic             re,
  input  logic [SET_W-1:0] raddr,
  output row_t             rdata,
  input  logic             we,
  input  logic [SET_W-1:0] waddr,
  input  row_t             wdata
);

  row_t mem [SETS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/alcr_policy.sv]
// Window counters, policy scores, policy register and configuration registers.
`timescale 1ns / 1ps
module alcr_policy
  import alcr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 upd,
  input  logic                 hit,
  output pol_t                 pol
);

  logic [CNT_W-1:0]    window_length;
  logic [FACTOR_W-1:0] miss_ratio_factor;
  logic [CNT_W-1:0]    score_limit;
  logic                policy;
  logic                policy_next;
  logic [CNT_W-1:0]    access_count;
  logic [CNT_W-1:0]    access_count_next;
  logic [CNT_W-1:0]    miss_count;
  logic [CNT_W-1:0]    miss_count_next;
  logic [SCORE_W-1:0]  score_lru;
  logic [SCORE_W-1:0]  score_lru_next;
  logic [SCORE_W-1:0]  score_clock;
  logic [SCORE_W-1:0]  score_clock_next;
  logic [CNT_W-1:0]    acc_inc;
  logic [CNT_W-1:0]    miss_inc;
  logic [PROD_W-1:0]   prod;
  logic [SCORE_W:0]    score_sum;

  always_comb begin
    acc_inc           = access_count + CNT_W'(1);
    miss_inc          = hit ? miss_count : miss_count + CNT_W'(1);
    prod              = PROD_W'(miss_inc) * PROD_W'(miss_ratio_factor);
    policy_next       = policy;
    access_count_next = acc_inc;
    miss_count_next   = miss_inc;
    score_lru_next    = score_lru;
    score_clock_next  = score_clock;
    score_sum         = '0;
    if (acc_inc >= window_length) begin
      access_count_next = '0;
      miss_count_next   = '0;
      if (prod > PROD_W'(acc_inc)) begin
        policy_next = ~policy;
      end else if (policy == POL_LRU) begin
        score_lru_next = score_lru + SCORE_W'(1);
      end else begin
        score_clock_next = score_clock + SCORE_W'(1);
      end
      score_sum = {1'b0, score_lru_next} + {1'b0, score_clock_next};
      if (score_sum > (SCORE_W + 1)'(score_limit)) begin
        score_lru_next   = '0;
        score_clock_next = SCORE_W'(1);
      end
    end
  end

  always_comb begin
    pol.policy_after = upd ? policy_next : policy;
    if (policy == POL_LRU) begin
      pol.use_lru = score_lru >= score_clock;
    end else begin
      pol.use_lru = score_clock < score_lru;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy       <= POL_CLOCK;
      access_count <= '0;
      miss_count   <= '0;
      score_lru    <= '0;
      score_clock  <= SCORE_W'(1);
    end else if (upd) begin
      policy       <= policy_next;
      access_count <= access_count_next;
      miss_count   <= miss_count_next;
      score_lru    <= score_lru_next;
      score_clock  <= score_clock_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length     <= WINDOW_RST;
      miss_ratio_factor <= FACTOR_RST;
      score_limit       <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW: window_length     <= cfg_data[CNT_W-1:0];
        CFG_FACTOR: miss_ratio_factor <= cfg_data[FACTOR_W-1:0];
        CFG_LIMIT:  score_limit       <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/alcr_row_update.sv]
// Row modification: LRU aging, used bits, and victim choice over one set.
`timescale 1ns / 1ps
module alcr_row_update
  import alcr_pkg::*;
(
  input  row_t             row_in,
  input  logic             req_type,
  input  logic [WAY_W-1:0] way,
  input  logic             hit,
  input  pol_t             pol,
  output row_t             row_out,
  output logic [WAY_W-1:0] victim
);

  logic [AGE_W-1:0] cur;
  logic [WAY_W-1:0] lru_victim;
  logic [WAY_W-1:0] h0;
  logic [WAY_W:0]   pos;
  logic [WAY_W:0]   vdist;
  logic [WAY_W-1:0] clk_victim;
  logic [WAY_W:0]   way_offset [WAYS];

  always_comb begin
    lru_victim = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_in.age[w] == AGE_W'(WAYS - 1)) begin
        lru_victim = WAY_W'(w);
      end
    end
  end

  always_comb begin
    if ({1'b0, row_in.hand} >= (WAY_W + 1)'(WAYS)) begin
      h0 = '0;
    end else begin
      h0 = row_in.hand;
    end
    vdist      = (WAY_W + 1)'(WAYS);
    clk_victim = h0;
    pos        = '0;
    for (int k = WAYS - 1; k >= 0; k--) begin
      pos = {1'b0, h0} + (WAY_W + 1)'(k);
      if (pos >= (WAY_W + 1)'(WAYS)) begin
        pos = pos - (WAY_W + 1)'(WAYS);
      end
      if (!row_in.used[pos[WAY_W-1:0]]) begin
        vdist      = (WAY_W + 1)'(k);
        clk_victim = pos[WAY_W-1:0];
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if ((WAY_W + 1)'(w) >= {1'b0, h0}) begin
        way_offset[w] = (WAY_W + 1)'(w) - {1'b0, h0};
      end else begin
        way_offset[w] = (WAY_W + 1)'(w) + (WAY_W + 1)'(WAYS) - {1'b0, h0};
      end
    end
  end

  always_comb begin
    row_out = row_in;
    cur     = row_in.age[way];
    victim  = '0;
    if (req_type == REQ_UPDATE) begin
      if ((WAY_W + 1)'(way) < (WAY_W + 1)'(WAYS)) begin
        if (pol.policy_after == POL_LRU) begin
          for (int w = 0; w < WAYS; w++) begin
            if (row_in.age[w] < cur) begin
              row_out.age[w] = row_in.age[w] + AGE_W'(1);
            end
          end
          row_out.age[way] = '0;
        end else if (hit) begin
          row_out.used[way] = 1'b1;
        end
      end
    end else if (pol.use_lru) begin
      victim = lru_victim;
    end else begin
      victim = clk_victim;
      row_out.hand = clk_victim;
      for (int w = 0; w < WAYS; w++) begin
        if (way_offset[w] < vdist) begin
          row_out.used[w] = 1'b0;
        end
      end
    end
  end

endmodule

[hw/rtl/adaptive_lru_clock_replacement_unit.sv]
// Top level of the adaptive LRU/CLOCK cache replacement unit.
//
//   Channel   Handshake            Payload
//   request   start / busy         req (req_type, set_index, way, hit)
//   result    done (one cycle)     rsp (victim_way, victim_valid, policy_now)
//   config    cfg_we               cfg_index, cfg_data
//
// For every item, the set's row is read from the row memory in the
// cycle after acceptance, then modified and written back while the result is
// registered. Busy is high for one cycle after each accepted item.
// After reset a clearing pass writes the reset row into all SETS rows with busy
// high; configuration writes are taken throughout.
// The receiver cannot stall: done is high for exactly one cycle per item.
`timescale 1ns / 1ps
module adaptive_lru_clock_replacement_unit
  import alcr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req,
  output logic                 done,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  state_t           state;
  state_t           state_next;
  logic [SET_W-1:0] clr_addr;
  req_t             item;
  logic             accept;
  logic             exec;
  logic             upd;
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  row_t             ram_wdata;
  row_t             row_rd;
  row_t             row_new;
  logic [WAY_W-1:0] victim;
  pol_t             pol;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == SET_W'(SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    accept    = 1'b0;
    exec      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = reset_row();
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      ST_EXEC: begin
        exec      = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = item.set_index;
        ram_wdata = row_new;
      end
      default: ;
    endcase
    upd = exec && (item.req_type == REQ_UPDATE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= exec;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + SET_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (exec) begin
      rsp.victim_way   <= victim;
      rsp.victim_valid <= item.req_type;
      rsp.policy_now   <= pol.policy_after;
    end
  end

  alcr_row_ram u_ram (
    .clk   (clk),
    .re    (accept),
    .raddr (req.set_index),
    .rdata (row_rd),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata)
  );

  alcr_policy u_policy (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .upd       (upd),
    .hit       (item.hit),
    .pol       (pol)
  );

  alcr_row_update u_row (
    .row_in   (row_rd),
    .req_type (item.req_type),
    .way      (item.way),
    .hit      (item.hit),
    .pol      (pol),
    .row_out  (row_new),
    .victim   (victim)
  );

endmodule

[hw/rtl/alcr_checker.sv]
// Port-level checker of the replacement unit and its bind to the top level.
`timescale 1ns / 1ps
`include "adaptive_lru_clock_replacement_unit_macros.svh"
module alcr_checker
  import alcr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  `ALCR_ASSERT_LATER(a_item_done, start && !busy, done, "Accepted item gave no result.")
  `ALCR_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "Busy did not rise.")
  `ALCR_ASSERT_NEXT(a_done_pulse, done, !done, "Result strobe lasted two cycles.")
  `ALCR_ASSERT_NOW(a_update_way, done && !rsp.victim_valid, rsp.victim_way == '0,
                   "Update item returned a nonzero way.")

endmodule

bind adaptive_lru_clock_replacement_unit alcr_checker u_alcr_checker (.*);

[test/adaptive_lru_clock_replacement_unit_tb.sv]
// Self-checking testbench for the adaptive LRU/CLOCK replacement unit.
`timescale 1ns / 1ps
module adaptive_lru_clock_replacement_unit_tb;
  import alcr_pkg::*;

  localparam int HANG_LIMIT = 4000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 req = '0;
  logic                 done;
  rsp_t                 rsp;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic [AGE_W-1:0]    age_tab [SETS][WAYS];
  logic [WAYS-1:0]     used_tab [SETS];
  logic [WAY_W-1:0]    hand_tab [SETS];
  logic                cur_policy;
  logic [CNT_W-1:0]    win_accesses;
  logic [CNT_W-1:0]    win_misses;
  logic [SCORE_W-1:0]  lru_score;
  logic [SCORE_W-1:0]  clock_score;
  logic [CNT_W-1:0]    cfg_window;
  logic [FACTOR_W-1:0] cfg_factor;
  logic [CNT_W-1:0]    cfg_limit;

  rsp_t        replace_rsp_q [$];
  rsp_t        want_rsp;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;

  adaptive_lru_clock_replacement_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void reset_sets();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        age_tab[s][w] = AGE_W'(w);
      end
      used_tab[s] = '0;
      hand_tab[s] = '0;
    end
    cur_policy   = POL_CLOCK;
    win_accesses = '0;
    win_misses   = '0;
    lru_score    = '0;
    clock_score  = SCORE_W'(1);
    cfg_window   = WINDOW_RST;
    cfg_factor   = FACTOR_RST;
    cfg_limit    = LIMIT_RST;
  endfunction

  function automatic rsp_t replace_step(input req_t item);
    rsp_t             o;
    int unsigned      s;
    int unsigned      h;
    int unsigned      n;
    logic [AGE_W-1:0] cur;
    logic             lru_pick;
    s = item.set_index % SETS;
    o = '0;
    if (item.req_type == REQ_UPDATE) begin
      win_accesses = win_accesses + 1'b1;
      if (!item.hit) begin
        win_misses = win_misses + 1'b1;
      end
      if (win_accesses >= cfg_window) begin
        if (32'(win_misses) * 32'(cfg_factor) > 32'(win_accesses)) begin
          cur_policy = ~cur_policy;
        end else if (cur_policy == POL_LRU) begin
          lru_score = lru_score + 1'b1;
        end else begin
          clock_score = clock_score + 1'b1;
        end
        win_accesses = '0;
        win_misses   = '0;
        if ({1'b0, lru_score} + {1'b0, clock_score} > {2'b00, cfg_limit}) begin
          lru_score   = '0;
          clock_score = SCORE_W'(1);
        end
      end
      if (cur_policy == POL_LRU) begin
        cur = age_tab[s][item.way];
        for (int w = 0; w < WAYS; w++) begin
          if (age_tab[s][w] < cur) begin
            age_tab[s][w] = age_tab[s][w] + 1'b1;
          end
        end
        age_tab[s][item.way] = '0;
      end else if (item.hit) begin
        used_tab[s][item.way] = 1'b1;
      end
    end else begin
      if (cur_policy == POL_LRU) begin
        lru_pick = (lru_score >= clock_score);
      end else begin
        lru_pick = (clock_score < lru_score);
      end
      if (lru_pick) begin
        for (int w = WAYS - 1; w >= 0; w--) begin
          if (age_tab[s][w] == AGE_W'(WAYS - 1)) begin
            o.victim_way = WAY_W'(w);
          end
        end
      end else begin
        h = hand_tab[s];
        n = 0;
        while (n <= WAYS && used_tab[s][h]) begin
          used_tab[s][h] = 1'b0;
          h = (h == WAYS - 1) ? 0 : h + 1;
          n++;
        end
        hand_tab[s] = WAY_W'(h);
        o.victim_way = WAY_W'(h);
      end
      o.victim_valid = 1'b1;
    end
    o.policy_now = cur_policy;
    return o;
  endfunction

  function automatic req_t make_req(input logic kind, input int unsigned set_no,
                                    input int unsigned way_no, input logic was_hit);
    req_t r;
    r.req_type  = kind;
    r.set_index = SET_W'(set_no);
    r.way       = WAY_W'(way_no);
    r.hit       = was_hit;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("MISMATCH at %0t ns: %s", $realtime, what);
    end
  endtask

  task automatic send_item(input req_t item);
    start <= 1'b1;
    req   <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    replace_rsp_q.push_back(replace_step(item));
  endtask

  task automatic idle_gap(input int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (replace_rsp_q.size() != 0);
  endtask

  task automatic program_regs(input logic [CNT_W-1:0] window,
                              input logic [FACTOR_W-1:0] factor,
                              input logic [CNT_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW;
    cfg_data  <= window;
    @(posedge clk);
    cfg_index <= CFG_FACTOR;
    cfg_data  <= {{(CFG_W - FACTOR_W){1'b0}}, factor};
    @(posedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_window = window;
    cfg_factor = factor;
    cfg_limit  = limit;
  endtask

  // Most items go to a few sets so that ages, used bits and hands build up.
  task automatic random_traffic(input int unsigned count, input bit with_gaps,
                                input int unsigned hit_pct);
    req_t        item;
    int unsigned burst;
    int unsigned pool [4];
    for (int i = 0; i < 4; i++) begin
      pool[i] = $urandom_range(0, SETS - 1);
    end
    burst = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        if (with_gaps) begin
          idle_gap($urandom_range(0, 6));
        end
        if ($urandom_range(0, 29) == 0) begin
          wait_quiet();
        end
      end
      burst--;
      item.req_type  = ($urandom_range(0, 9) < 3) ? REQ_VICTIM : REQ_UPDATE;
      item.set_index = ($urandom_range(0, 9) == 0) ? SET_W'($urandom)
                                                    : SET_W'(pool[$urandom_range(0, 3)]);
      item.way       = WAY_W'($urandom);
      item.hit       = ($urandom_range(0, 99) < hit_pct);
      send_item(item);
    end
  endtask

  task automatic test_directed_cases();
    send_item(make_req(REQ_VICTIM, 0, 0, 1'b0));
    send_item(make_req(REQ_UPDATE, 1023, 15, 1'b1));
    send_item(make_req(REQ_UPDATE, 1023, 0, 1'b1));
    send_item(make_req(REQ_VICTIM, 1023, 15, 1'b1));
    send_item(make_req(REQ_VICTIM, 1023, 0, 1'b0));
    send_item(make_req(REQ_UPDATE, 512, 0, 1'b0));
    wait_quiet();
    program_regs('0, '0, '1);
    send_item(make_req(REQ_UPDATE, 512, 7, 1'b0));
    send_item(make_req(REQ_UPDATE, 341, 10, 1'b1));
    wait_quiet();
    program_regs(16'd1, 8'd255, '1);
    send_item(make_req(REQ_UPDATE, 1023, 15, 1'b0));
    send_item(make_req(REQ_UPDATE, 1023, 3, 1'b1));
    send_item(make_req(REQ_VICTIM, 1023, 0, 1'b0));
    send_item(make_req(REQ_UPDATE, 1023, 3, 1'b1));
    send_item(make_req(REQ_VICTIM, 1023, 5, 1'b1));
    wait_quiet();
    program_regs(16'd1, 8'd255, '0);
    send_item(make_req(REQ_UPDATE, 682, 8, 1'b1));
    send_item(make_req(REQ_VICTIM, 682, 0, 1'b0));
    send_item(make_req(REQ_UPDATE, 0, 15, 1'b0));
    send_item(make_req(REQ_VICTIM, 1023, 15, 1'b1));
    wait_quiet();
  endtask

  task automatic test_policy_switching();
    repeat (2) begin
      program_regs(CNT_W'($urandom_range(1, 8)), FACTOR_W'($urandom_range(2, 4)),
                   CNT_W'($urandom_range(1, 12)));
      random_traffic(150, 1'b1, 60);
      wait_quiet();
    end
  endtask

  task automatic test_score_growth();
    program_regs(CNT_W'($urandom_range(1, 4)), '0, '1);
    random_traffic(100, 1'b1, 50);
    wait_quiet();
  endtask

  task automatic test_extreme_settings();
    program_regs('1, '1, '1);
    random_traffic(80, 1'b1, 40);
    wait_quiet();
    program_regs(WINDOW_RST, FACTOR_RST, LIMIT_RST);
    random_traffic(80, 1'b1, 70);
    wait_quiet();
  endtask

  task automatic test_back_to_back();
    program_regs(CNT_W'($urandom_range(1, 6)), FACTOR_W'($urandom_range(1, 255)),
                 CNT_W'($urandom_range(1, 20)));
    random_traffic(190, 1'b0, 55);
    wait_quiet();
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (replace_rsp_q.size() == 0) begin
        report_mismatch("result strobe with no item outstanding");
      end else begin
        want_rsp = replace_rsp_q.pop_front();
        if (rsp.victim_way !== want_rsp.victim_way) begin
          report_mismatch($sformatf("victim_way %0d, predicted %0d",
                                    rsp.victim_way, want_rsp.victim_way));
        end
        if (rsp.victim_valid !== want_rsp.victim_valid) begin
          report_mismatch($sformatf("victim_valid %b, predicted %b",
                                    rsp.victim_valid, want_rsp.victim_valid));
        end
        if (rsp.policy_now !== want_rsp.policy_now) begin
          report_mismatch($sformatf("policy_now %b, predicted %b",
                                    rsp.policy_now, want_rsp.policy_now));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
      if (stall_cycles >= HANG_LIMIT) begin
        $display("adaptive_lru_clock_replacement_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    reset_sets();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_policy_switching();
    test_score_growth();
    test_extreme_settings();
    test_back_to_back();
    wait_quiet();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("adaptive_lru_clock_replacement_unit verification clean");
    end else begin
      $display("adaptive_lru_clock_replacement_unit verification failed");
    end
    $finish;
  end

endmodule
